// ===== sv/msadpcm_pkg.sv =====
// Shared types and constant tables for the stereo MS ADPCM decoder.
`default_nettype none
package msadpcm_pkg;

   localparam int unsigned PreambleBytes = 14;
   localparam int unsigned BlockMin      = 15;
   localparam int unsigned BlockMax      = 8192;
   localparam int unsigned BlockReset    = 1024;

   localparam logic [2:0]         MaxPredictor = 3'd6;
   localparam logic signed [23:0] DeltaFloor   = 24'sd16;
   localparam logic signed [23:0] DeltaMax     = 24'sd8388607;
   localparam logic signed [15:0] SampleMin    = -16'sd32768;
   localparam logic signed [15:0] SampleMax    = 16'sd32767;

   localparam logic signed [10:0] AdaptGain [16] = '{
      11'sd230, 11'sd230, 11'sd230, 11'sd230, 11'sd307, 11'sd409, 11'sd512, 11'sd614,
      11'sd768, 11'sd614, 11'sd512, 11'sd409, 11'sd307, 11'sd230, 11'sd230, 11'sd230
   };

   localparam logic signed [10:0] CoefA [7] = '{
      11'sd256, 11'sd512, 11'sd0, 11'sd192, 11'sd240, 11'sd460, 11'sd392
   };

   localparam logic signed [10:0] CoefB [7] = '{
      11'sd0, -11'sd256, 11'sd0, 11'sd64, 11'sd0, -11'sd208, -11'sd232
   };

   typedef enum logic [1:0] {
      FIELD_DELTA = 2'd0,
      FIELD_NEWER = 2'd1,
      FIELD_OLDER = 2'd2
   } field_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [23:0] delta;
   } chan_result_type;

endpackage
`default_nettype wire

// ===== sv/ms_adpcm_stereo_decoder_unit.sv =====
// Stereo MS ADPCM decoder: one stream byte in, one left/right sample pair out per data byte.
//
//   channel  direction  payload                           handshake
//   req      in         data_byte[7:0], restart           req_valid / req_ready
//   rsp      out        left_sample[15:0], right_sample   rsp_valid / rsp_ready
//   csr      in         data[13:0] (block_bytes)          csr_valid / csr_ready
//
// One byte per cycle while req_ready is high: a byte updates the channel state when accepted
// and the next byte reads that state; both channels' predictor and delta update sets this rate.
// A data byte puts the older stored pair, not the pair it decodes, in the output register the
// cycle after acceptance. Preamble bytes give no result. Reset is synchronous and needs no
// clearing pass. req_ready drops only while the output register is full and rsp_ready is low.
`default_nettype none
module ms_adpcm_stereo_decoder_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_data_byte,
   input  wire                req_restart,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [13:0]        csr_data
);

   function automatic msadpcm_pkg::chan_result_type decode_chan(
      input logic [3:0]         nib,
      input logic [2:0]         ci,
      input logic signed [23:0] delta,
      input logic signed [15:0] newer,
      input logic signed [15:0] older
   );
      logic [2:0]         cic;
      logic signed [3:0]  code;
      logic signed [10:0] ca;
      logic signed [10:0] cb;
      logic signed [10:0] gain;
      logic signed [26:0] pa;
      logic signed [26:0] pb;
      logic signed [27:0] psum;
      logic signed [27:0] pround;
      logic signed [19:0] pdiv;
      logic signed [27:0] step;
      logic signed [29:0] total;
      logic signed [34:0] dprod;
      logic signed [34:0] dround;
      logic signed [26:0] ddiv;
      msadpcm_pkg::chan_result_type res;
      cic    = (ci > msadpcm_pkg::MaxPredictor) ? msadpcm_pkg::MaxPredictor : ci;
      code   = nib;
      ca     = msadpcm_pkg::CoefA[cic];
      cb     = msadpcm_pkg::CoefB[cic];
      gain   = msadpcm_pkg::AdaptGain[nib];
      pa     = newer * ca;
      pb     = older * cb;
      psum   = 28'(pa) + 28'(pb);
      pround = psum + (psum[27] ? 28'sd255 : 28'sd0);
      pdiv   = pround[27:8];
      step   = code * delta;
      total  = 30'(pdiv) + 30'(step);
      if (total < 30'(msadpcm_pkg::SampleMin)) begin
         res.sample = msadpcm_pkg::SampleMin;
      end else if (total > 30'(msadpcm_pkg::SampleMax)) begin
         res.sample = msadpcm_pkg::SampleMax;
      end else begin
         res.sample = total[15:0];
      end
      dprod  = gain * delta;
      dround = dprod + (dprod[34] ? 35'sd255 : 35'sd0);
      ddiv   = dround[34:8];
      if (ddiv > 27'(msadpcm_pkg::DeltaMax)) begin
         res.delta = msadpcm_pkg::DeltaMax;
      end else if (ddiv < 27'(msadpcm_pkg::DeltaFloor)) begin
         res.delta = msadpcm_pkg::DeltaFloor;
      end else begin
         res.delta = ddiv[23:0];
      end
      return res;
   endfunction

   logic [13:0]        block_bytes_ff;
   logic [12:0]        byte_position_ff, byte_position_in;
   logic [7:0]         low_byte_hold_ff, low_byte_hold_in;
   logic [2:0]         coef_index_ff [2];
   logic [2:0]         coef_index_in [2];
   logic signed [23:0] step_delta_ff [2];
   logic signed [23:0] step_delta_in [2];
   logic signed [15:0] newer_sample_ff [2];
   logic signed [15:0] newer_sample_in [2];
   logic signed [15:0] older_sample_ff [2];
   logic signed [15:0] older_sample_in [2];
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_left_ff, rsp_left_in;
   logic signed [15:0] rsp_right_ff, rsp_right_in;

   logic                          accept;
   logic [12:0]                   pos;
   logic [13:0]                   pos_next;
   logic [13:0]                   block_len;
   logic [3:0]                    pre_off;
   logic                          pre_ch;
   msadpcm_pkg::field_type        pre_field;
   logic signed [15:0]            pre_value;
   msadpcm_pkg::chan_result_type  left_res;
   msadpcm_pkg::chan_result_type  right_res;

   assign csr_ready        = 1'b1;
   assign req_ready        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;
   assign accept           = req_valid && req_ready;

   always_comb begin
      if (block_bytes_ff < 14'(msadpcm_pkg::BlockMin)) begin
         block_len = 14'(msadpcm_pkg::BlockMin);
      end else if (block_bytes_ff > 14'(msadpcm_pkg::BlockMax)) begin
         block_len = 14'(msadpcm_pkg::BlockMax);
      end else begin
         block_len = block_bytes_ff;
      end
   end

   assign pos       = req_restart ? 13'd0 : byte_position_ff;
   assign pos_next  = 14'(pos) + 14'd1;
   assign pre_off   = pos[3:0] - 4'd3;
   assign pre_ch    = pre_off[1];
   assign pre_value = {req_data_byte, low_byte_hold_ff};

   always_comb begin
      unique case (pre_off[3:2])
         2'd0:    pre_field = msadpcm_pkg::FIELD_DELTA;
         2'd1:    pre_field = msadpcm_pkg::FIELD_NEWER;
         default: pre_field = msadpcm_pkg::FIELD_OLDER;
      endcase
   end

   assign left_res  = decode_chan(req_data_byte[7:4], coef_index_ff[0], step_delta_ff[0],
                                  newer_sample_ff[0], older_sample_ff[0]);
   assign right_res = decode_chan(req_data_byte[3:0], coef_index_ff[1], step_delta_ff[1],
                                  newer_sample_ff[1], older_sample_ff[1]);

   always_comb begin
      byte_position_in = byte_position_ff;
      low_byte_hold_in = low_byte_hold_ff;
      coef_index_in    = coef_index_ff;
      step_delta_in    = step_delta_ff;
      newer_sample_in  = newer_sample_ff;
      older_sample_in  = older_sample_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_left_in      = rsp_left_ff;
      rsp_right_in     = rsp_right_ff;
      if (accept) begin
         if (pos < 13'(msadpcm_pkg::PreambleBytes)) begin
            byte_position_in = pos_next[12:0];
            if (pos < 13'd2) begin
               coef_index_in[pos[0]] = (req_data_byte > 8'(msadpcm_pkg::MaxPredictor)) ?
                                       msadpcm_pkg::MaxPredictor : req_data_byte[2:0];
            end else if (!pos[0]) begin
               low_byte_hold_in = req_data_byte;
            end else begin
               unique case (pre_field)
                  msadpcm_pkg::FIELD_DELTA: step_delta_in[pre_ch]   = 24'(pre_value);
                  msadpcm_pkg::FIELD_NEWER: newer_sample_in[pre_ch] = pre_value;
                  msadpcm_pkg::FIELD_OLDER: older_sample_in[pre_ch] = pre_value;
                  default:                  older_sample_in[pre_ch] = pre_value;
               endcase
            end
         end else begin
            byte_position_in   = (pos_next >= block_len) ? 13'd0 : pos_next[12:0];
            older_sample_in[0] = newer_sample_ff[0];
            older_sample_in[1] = newer_sample_ff[1];
            newer_sample_in[0] = left_res.sample;
            newer_sample_in[1] = right_res.sample;
            step_delta_in[0]   = left_res.delta;
            step_delta_in[1]   = right_res.delta;
            rsp_valid_in       = 1'b1;
            rsp_left_in        = older_sample_ff[0];
            rsp_right_in       = older_sample_ff[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff   <= 14'(msadpcm_pkg::BlockReset);
         byte_position_ff <= '0;
         low_byte_hold_ff <= '0;
         coef_index_ff    <= '{3'd0, 3'd0};
         step_delta_ff    <= '{msadpcm_pkg::DeltaFloor, msadpcm_pkg::DeltaFloor};
         newer_sample_ff  <= '{16'sd0, 16'sd0};
         older_sample_ff  <= '{16'sd0, 16'sd0};
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            block_bytes_ff <= csr_data;
         end
         byte_position_ff <= byte_position_in;
         low_byte_hold_ff <= low_byte_hold_in;
         coef_index_ff    <= coef_index_in;
         step_delta_ff    <= step_delta_in;
         newer_sample_ff  <= newer_sample_in;
         older_sample_ff  <= older_sample_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

endmodule
`default_nettype wire
